>>> src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared definitions for the LRU key-value cache
// Sizes, derived widths, the sequencer state type and the get-miss value.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  // Number of slots in the store.
  localparam int ENTRIES = 16;
  // Slot index and rank width.
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Scan counter width: must hold ENTRIES itself.
  localparam int CNT_W   = IDX_W + 1;
  // Occupancy width: 0 to ENTRIES.
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  // Field widths fixed by the interface.
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Read value returned by a get that misses.
  localparam logic [VAL_W-1:0] READ_MISS = '1;

  // Request actions.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Request sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Each request beat is a get or a put. Keys and values live in two
// single-port synchronous memories; valid bits and recency ranks (0 = most
// recent) sit in flip-flops. A request scans the key memory one slot per
// cycle through its read port and stops at a hit or after the last slot.
// The scan also finds the lowest free slot and the least recent entry; the
// update state then writes the memories and ages the affected ranks in
// parallel. Results sit in an output register, so a new request is taken
// while a finished result waits. A get miss returns -1; a put returns 0.
// The capacity register (0 acts as 1, above ENTRIES acts as ENTRIES) may
// be written only while the block is idle; lowering it below the occupancy
// drops nothing, each later insert simply evicts one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_action,
  input  wire logic [lkv_pkg::KEY_W-1:0]   in_key,
  input  wire logic signed [lkv_pkg::VAL_W-1:0] in_value,
  // Result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_evicted,
  // Capacity register write channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_data
);

  localparam int ENTRIES = lkv_pkg::ENTRIES;
  localparam int IDX_W   = lkv_pkg::IDX_W;
  localparam int CNT_W   = lkv_pkg::CNT_W;
  localparam int OCC_W   = lkv_pkg::OCC_W;
  localparam int KEY_W   = lkv_pkg::KEY_W;
  localparam int VAL_W   = lkv_pkg::VAL_W;
  localparam int CAP_W   = lkv_pkg::CAP_W;

  // Sequencer and request registers.
  lkv_pkg::state_t     state_r, state_nxt;
  logic                action_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    value_r;

  // Scan pipeline.
  logic [CNT_W-1:0]    issue_cnt_r, issue_cnt_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    found_idx_r, found_idx_nxt;
  logic                free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic                vict_ok_r, vict_ok_nxt;
  logic [IDX_W-1:0]    vict_idx_r, vict_idx_nxt;
  logic                evicted_r, evicted_nxt;

  // Slot state in flip-flops.
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [IDX_W-1:0]    rank_r   [ENTRIES];
  logic [IDX_W-1:0]    rank_nxt [ENTRIES];
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [CAP_W-1:0]    cap_r;

  // Memories and their registered read data.
  logic [KEY_W-1:0]    key_mem [ENTRIES];
  logic [VAL_W-1:0]    val_mem [ENTRIES];
  logic [KEY_W-1:0]    key_rd_r;
  logic [VAL_W-1:0]    val_rd_r;

  // Output register.
  logic                out_valid_r, out_hit_r, out_evicted_r;
  logic [VAL_W-1:0]    out_read_value_r;

  // Control decoded from the state.
  logic                in_acc;
  logic                key_re;
  logic                upd_en;
  logic                out_free;
  logic                out_load;
  logic                cmp_match;
  logic                scan_end;

  // Update-cycle decisions.
  logic [OCC_W-1:0]    eff_cap;
  logic                need_evict;
  logic [IDX_W-1:0]    ins_idx;
  logic                key_we, val_we, val_re;
  logic [IDX_W-1:0]    val_addr;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Compare stage of the scan: the read issued last cycle is checked here.
  assign cmp_match = rd_pend_r && valid_r[rd_idx_r] && (key_rd_r == key_r);
  assign scan_end  = rd_pend_r && (cmp_match || (rd_idx_r == IDX_W'(ENTRIES - 1)));

  // Capacity as used: zero acts as one, too large acts as the slot count.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = OCC_W'(1);
    end else if (int'(cap_r) > ENTRIES) begin
      eff_cap = OCC_W'(ENTRIES);
    end else begin
      eff_cap = OCC_W'(cap_r);
    end
  end

  // Insert decisions: evict when one more entry would exceed capacity, then
  // fill the lowest free slot, which may be the one just vacated.
  assign need_evict = (action_r == lkv_pkg::ACT_PUT) && !found_r && (occ_r >= eff_cap);
  assign ins_idx    = (need_evict && vict_ok_r && (!free_ok_r || (vict_idx_r < free_idx_r)))
                      ? vict_idx_r : free_idx_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkv_pkg::ST_IDLE:   if (in_acc)   state_nxt = lkv_pkg::ST_SCAN;
      lkv_pkg::ST_SCAN:   if (scan_end) state_nxt = lkv_pkg::ST_UPDATE;
      lkv_pkg::ST_UPDATE: state_nxt = lkv_pkg::ST_DONE;
      lkv_pkg::ST_DONE:   if (out_free) state_nxt = lkv_pkg::ST_IDLE;
      default:            state_nxt = lkv_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    key_re   = 1'b0;
    upd_en   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      lkv_pkg::ST_IDLE:   in_stall = 1'b0;
      lkv_pkg::ST_SCAN:   key_re   = (issue_cnt_r < CNT_W'(ENTRIES));
      lkv_pkg::ST_UPDATE: upd_en   = 1'b1;
      lkv_pkg::ST_DONE:   out_load = out_free;
      default:            in_stall = 1'b1;
    endcase
  end

  // Scan bookkeeping: issue one key read per cycle and record the match,
  // the lowest free slot and the least recent valid slot.
  always_comb begin
    issue_cnt_nxt = issue_cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    vict_ok_nxt   = vict_ok_r;
    vict_idx_nxt  = vict_idx_r;
    if (in_acc) begin
      issue_cnt_nxt = '0;
      found_nxt     = 1'b0;
      free_ok_nxt   = 1'b0;
      vict_ok_nxt   = 1'b0;
    end else if (state_r == lkv_pkg::ST_SCAN) begin
      if (key_re) begin
        issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
        rd_pend_nxt   = !scan_end;
        rd_idx_nxt    = issue_cnt_r[IDX_W-1:0];
      end
      if (rd_pend_r) begin
        if (cmp_match) begin
          found_nxt     = 1'b1;
          found_idx_nxt = rd_idx_r;
        end
        if (!valid_r[rd_idx_r] && !free_ok_r) begin
          free_ok_nxt  = 1'b1;
          free_idx_nxt = rd_idx_r;
        end
        if (valid_r[rd_idx_r] && !vict_ok_r &&
            (rank_r[rd_idx_r] == IDX_W'(occ_r - OCC_W'(1)))) begin
          vict_ok_nxt  = 1'b1;
          vict_idx_nxt = rd_idx_r;
        end
      end
    end
  end

  // Update cycle: ranks age in parallel, valid bits and occupancy follow.
  always_comb begin
    logic [ENTRIES-1:0] keep;
    valid_nxt   = valid_r;
    occ_nxt     = occ_r;
    evicted_nxt = evicted_r;
    keep        = valid_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (upd_en) begin
      evicted_nxt = need_evict;
      if (found_r) begin
        // Hit: entries more recent than the found one age by one.
        for (int i = 0; i < ENTRIES; i++) begin
          if (i == int'(found_idx_r)) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < rank_r[found_idx_r])) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
      end else if (action_r == lkv_pkg::ACT_PUT) begin
        // Insert: drop the victim, age every survivor, new entry is newest.
        if (need_evict && vict_ok_r) begin
          keep[vict_idx_r] = 1'b0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (i == int'(ins_idx)) begin
            rank_nxt[i] = '0;
          end else if (keep[i]) begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end else begin
            rank_nxt[i] = '0;
          end
        end
        valid_nxt          = keep;
        valid_nxt[ins_idx] = 1'b1;
        occ_nxt = occ_r - OCC_W'(need_evict && vict_ok_r) + OCC_W'(1);
      end
    end
  end

  // Memory controls for the update cycle.
  assign key_we   = upd_en && (action_r == lkv_pkg::ACT_PUT) && !found_r;
  assign val_we   = upd_en && (action_r == lkv_pkg::ACT_PUT);
  assign val_re   = upd_en && (action_r == lkv_pkg::ACT_GET) && found_r;
  assign val_addr = found_r ? found_idx_r : ins_idx;

  // Key memory: one read or one write per cycle.
  always_ff @(posedge clk) begin
    if (key_re) begin
      key_rd_r <= key_mem[issue_cnt_r[IDX_W-1:0]];
    end
    if (key_we) begin
      key_mem[ins_idx] <= key_r;
    end
  end

  // Value memory: read on a get hit, written on every put.
  always_ff @(posedge clk) begin
    if (val_re) begin
      val_rd_r <= val_mem[val_addr];
    end
    if (val_we) begin
      val_mem[val_addr] <= value_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkv_pkg::ST_IDLE;
      valid_r     <= '0;
      occ_r       <= '0;
      cap_r       <= lkv_pkg::CAP_RESET;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      occ_r     <= occ_nxt;
      rd_pend_r <= rd_pend_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_action;
      key_r    <= in_key;
      value_r  <= in_value;
    end
    issue_cnt_r <= issue_cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    free_ok_r   <= free_ok_nxt;
    free_idx_r  <= free_idx_nxt;
    vict_ok_r   <= vict_ok_nxt;
    vict_idx_r  <= vict_idx_nxt;
    evicted_r   <= evicted_nxt;
    if (out_load) begin
      out_hit_r     <= found_r;
      out_evicted_r <= evicted_r;
      if (action_r == lkv_pkg::ACT_PUT) begin
        out_read_value_r <= '0;
      end else if (found_r) begin
        out_read_value_r <= val_rd_r;
      end else begin
        out_read_value_r <= lkv_pkg::READ_MISS;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_evicted    = out_evicted_r;

  // Occupancy always matches the number of valid slots.
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy differs from valid slot count");

  // Occupancy never exceeds the slot count.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= ENTRIES)
    else $error("occupancy above slot count");

  // An insert always finds a slot: a free one or a victim.
  a_ins_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && (action_r == lkv_pkg::ACT_PUT) && !found_r) |-> (free_ok_r || vict_ok_r))
    else $error("insert without a free slot or victim");

  // An eviction needs a victim that was found during the scan.
  a_evict_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && need_evict) |-> vict_ok_r)
    else $error("eviction without a least recent entry");

  // A result that reports an eviction cannot be a hit.
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !(out_evicted_r && out_hit_r))
    else $error("eviction reported on a hit");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU key-value cache
// Get and put beats are driven on the request channel, and the capacity
// register is rewritten between phases once the block has drained. A
// scoreboard keeps its own copy of the slots, keys, values and recency
// ranks, predicts hit, read value and eviction for every accepted request,
// and checks each result beat in order. Both channels idle and stall at
// random, with some phases left free of idling.
// ----------------------------------------------------------------------------

// Predicts the cache behavior and checks result beats against it.
class cache_scoreboard;
  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] read_value;
    logic                      evicted;
  } lookup_t;

  lookup_t                   expected_q[$];
  bit                        slot_used[lkv_pkg::ENTRIES];
  logic [lkv_pkg::KEY_W-1:0] slot_key[lkv_pkg::ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] slot_val[lkv_pkg::ENTRIES];
  int                        slot_age[lkv_pkg::ENTRIES];
  int                        fill;
  logic [lkv_pkg::CAP_W-1:0] capacity;
  int                        errors;

  function new();
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_age[i]  = 0;
    end
    fill     = 0;
    capacity = lkv_pkg::CAP_RESET;
    errors   = 0;
  endfunction

  function void set_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
    capacity = cap;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Print one line per mismatch and count it.
  task report_mismatch(string msg);
    errors++;
    $display("[%0t] %s", $time, msg);
  endtask

  // Move a slot to rank 0; entries that were more recent age by one.
  function void make_newest(int s);
    int old_age;
    old_age = slot_age[s];
    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
      if (slot_used[i] && slot_age[i] < old_age)
        slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Work out the result of an accepted request and update the cache copy.
  function void note_request(logic act, logic [lkv_pkg::KEY_W-1:0] key,
                             logic [lkv_pkg::VAL_W-1:0] val);
    int      found;
    int      eff_cap;
    lookup_t res;
    found = -1;
    res   = '0;
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == key) begin
        found = i;
        break;
      end
    end
    if (act == lkv_pkg::ACT_GET) begin
      if (found >= 0) begin
        res.hit        = 1'b1;
        res.read_value = slot_val[found];
        make_newest(found);
      end else begin
        res.read_value = lkv_pkg::READ_MISS;
      end
    end else if (found >= 0) begin
      res.hit         = 1'b1;
      slot_val[found] = val;
      make_newest(found);
    end else begin
      // Capacity 0 behaves as 1, anything above the slot count as full size.
      eff_cap = capacity;
      if (eff_cap < 1) eff_cap = 1;
      if (eff_cap > lkv_pkg::ENTRIES) eff_cap = lkv_pkg::ENTRIES;
      // Drop the least recent entry first when the insert would overflow.
      if (fill + 1 > eff_cap) begin
        res.evicted = 1'b1;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (fill > 0 && slot_used[i] && slot_age[i] == fill - 1) begin
            slot_used[i] = 1'b0;
            slot_age[i]  = 0;
            fill--;
            break;
          end
        end
      end
      // The new key goes into the lowest free slot as the most recent entry.
      for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
        if (!slot_used[i]) begin
          for (int j = 0; j < lkv_pkg::ENTRIES; j++)
            if (slot_used[j])
              slot_age[j]++;
          slot_used[i] = 1'b1;
          slot_key[i]  = key;
          slot_val[i]  = val;
          slot_age[i]  = 0;
          fill++;
          break;
        end
      end
    end
    expected_q.push_back(res);
  endfunction

  // Compare one result beat with the oldest prediction.
  task check_result(logic hit, logic [lkv_pkg::VAL_W-1:0] read_value,
                    logic evicted);
    lookup_t exp_res;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result beat with no request pending: hit %0b value %08h",
                                hit, read_value));
      return;
    end
    exp_res = expected_q.pop_front();
    if (hit !== exp_res.hit)
      report_mismatch($sformatf("hit: got %0b, expected %0b", hit, exp_res.hit));
    if (read_value !== exp_res.read_value)
      report_mismatch($sformatf("read_value: got %08h, expected %08h",
                                read_value, exp_res.read_value));
    if (evicted !== exp_res.evicted)
      report_mismatch($sformatf("evicted: got %0b, expected %0b",
                                evicted, exp_res.evicted));
  endtask
endclass

module testbench;

  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE       = lkv_pkg::ENTRIES + 8;
  localparam int PHASE_ITEMS  = 193;

  logic                             clk            = 1'b0;
  logic                             rst_n          = 1'b0;
  logic                             in_valid       = 1'b0;
  logic                             in_stall;
  logic                             in_action      = lkv_pkg::ACT_GET;
  logic [lkv_pkg::KEY_W-1:0]        in_key         = '0;
  logic signed [lkv_pkg::VAL_W-1:0] in_value       = '0;
  logic                             out_valid;
  logic                             out_stall      = 1'b0;
  logic                             out_hit;
  logic signed [lkv_pkg::VAL_W-1:0] out_read_value;
  logic                             out_evicted;
  logic                             cfg_valid      = 1'b0;
  logic                             cfg_ready;
  logic [lkv_pkg::CAP_W-1:0]        cfg_data       = '0;

  cache_scoreboard sb;
  bit              steady = 1'b0;
  int              stall_left = 0;
  int              idle_cycles = 0;

  lru_key_value_cache uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle length: mostly short, now and then a long one.
  function automatic int pick_idle_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!steady && $urandom_range(0, 99) < 30)
        stall_left <= pick_idle_len();
    end
  end

  // Beat monitors, prediction, checking and the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request(in_action, in_key, in_value);
      if (out_valid && !out_stall)
        sb.check_result(out_hit, out_read_value, out_evicted);
      if (cfg_valid && cfg_ready)
        sb.set_capacity(cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Drive one request beat, hold it until taken, then maybe leave a gap.
  task automatic send_request(logic act, logic [lkv_pkg::KEY_W-1:0] key,
                              logic [lkv_pkg::VAL_W-1:0] val);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_action <= act;
    in_key    <= key;
    in_value  <= val;
    do @(posedge clk); while (in_stall);
    gap = (!steady && $urandom_range(0, 99) < 40) ? pick_idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      in_action <= 1'($urandom_range(0, 1));
      in_key    <= $urandom;
      in_value  <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic over a key pool a little larger than the capacity.
  task automatic run_phase(logic [lkv_pkg::CAP_W-1:0] cap, int items, bit calm);
    logic [lkv_pkg::KEY_W-1:0] pool[$];
    logic [lkv_pkg::KEY_W-1:0] key;
    int                        eff_cap;
    int                        pool_size;
    wait_drained();
    write_capacity(cap);
    steady    = calm;
    eff_cap   = (cap < 1) ? 1 : ((cap > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : int'(cap));
    pool_size = eff_cap + $urandom_range(1, 6);
    for (int i = 0; i < pool_size; i++)
      pool.push_back($urandom);
    for (int i = 0; i < items; i++) begin
      key = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_size - 1)]
                                         : lkv_pkg::KEY_W'($urandom);
      send_request(($urandom_range(0, 99) < 50) ? lkv_pkg::ACT_PUT : lkv_pkg::ACT_GET,
                   key, $urandom);
    end
  endtask

  initial begin
    logic [lkv_pkg::CAP_W-1:0] caps[10];
    sb = new();
    caps = '{5'd31, 5'd1, 5'd17, 5'd3, 5'd16, 5'd8, 5'd2, 5'd5, 5'd12, 5'd16};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacity: empty lookup, extreme keys and values, updates.
    send_request(lkv_pkg::ACT_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(lkv_pkg::ACT_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(lkv_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0);
    send_request(lkv_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(lkv_pkg::ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    // A stored -1 must still read back as a hit.
    send_request(lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0);
    send_request(lkv_pkg::ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(lkv_pkg::ACT_PUT, 32'h5555_5555, 32'h5555_5555);
    send_request(lkv_pkg::ACT_PUT, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_request(lkv_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0);

    // Capacity 0 acts as 1 and sits below the occupancy: each insert evicts
    // one entry, while hits evict nothing.
    wait_drained();
    write_capacity(5'd0);
    send_request(lkv_pkg::ACT_PUT, 32'h0000_1234, 32'h0000_0001);
    send_request(lkv_pkg::ACT_GET, 32'h0000_1234, 32'h0);
    send_request(lkv_pkg::ACT_PUT, 32'h0000_5678, 32'h0000_0002);
    send_request(lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0);
    send_request(lkv_pkg::ACT_PUT, 32'h0000_5678, 32'h0000_0003);
    send_request(lkv_pkg::ACT_GET, 32'h0000_1234, 32'h0);

    // Random phases across the capacity range, some free of idling.
    for (int p = 0; p < 10; p++)
      run_phase(caps[p], PHASE_ITEMS, (p % 4) == 2);

    steady = 1'b0;
    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
